[rtl/printf_integer_field_formatter_top_macros.svh]
// ---------------------------------------------------------------------------
// printf_integer_field_formatter_top_macros
// Assertion macros for the integer field formatter.
// ---------------------------------------------------------------------------
`ifndef PRINTF_INTEGER_FIELD_FORMATTER_TOP_MACROS_SVH
`define PRINTF_INTEGER_FIELD_FORMATTER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define IFMT_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("ifmt assertion failed");
`define IFMT_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("ifmt assertion failed");
`else
`define IFMT_ASSERT_IMP(lbl, a, b)
`define IFMT_ASSERT_NXT(lbl, a, b)
`endif
`endif

[rtl/ifmt_pkg.sv]
// ---------------------------------------------------------------------------
// ifmt_pkg
// Shared types and constants of the integer field formatter.
// ---------------------------------------------------------------------------
package ifmt_pkg;

    localparam logic [2:0] KIND_LITERAL = 3'd0;
    localparam logic [2:0] KIND_SDEC    = 3'd1;
    localparam logic [2:0] KIND_UDEC    = 3'd2;
    localparam logic [2:0] KIND_HEXL    = 3'd3;
    localparam logic [2:0] KIND_HEXU    = 3'd4;
    localparam logic [2:0] KIND_PTR     = 3'd5;
    localparam logic [2:0] KIND_CHAR    = 3'd6;
    localparam logic [2:0] KIND_SHOWN   = 3'd7;

    localparam logic [1:0] SIZE_INT  = 2'd0;
    localparam logic [1:0] SIZE_HH   = 2'd1;
    localparam logic [1:0] SIZE_H    = 2'd2;
    localparam logic [1:0] SIZE_LONG = 2'd3;

    localparam int          RESULT_MAX = 48;
    localparam int          BCD_DIGITS = 20;
    localparam int          CONV_BITS  = 64;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_X_LOW   = 8'h78;
    localparam logic [7:0] CH_X_UP    = 8'h58;

    typedef struct packed {
        logic start;
        logic base16;
    } conv_req_t;

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        begin
            if (nib < 4'd10)
                c = CH_ZERO + {4'd0, nib};
            else if (upper)
                c = 8'h37 + {4'd0, nib};
            else
                c = 8'h57 + {4'd0, nib};
            return c;
        end
    endfunction

endpackage

[rtl/ifmt_bcd.sv]
// ---------------------------------------------------------------------------
// ifmt_bcd
// Digit extraction unit: shift-add-3 binary to BCD, or nibble pass-through.
// ---------------------------------------------------------------------------
module ifmt_bcd
    import ifmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  conv_req_t                 req,
    input  logic [CONV_BITS-1:0]      mag,
    output logic                      done,
    output logic [4*BCD_DIGITS-1:0]   digits
);

    logic [CONV_BITS-1:0]    bin_reg, bin_next;
    logic [4*BCD_DIGITS-1:0] bcd_reg, bcd_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [4*BCD_DIGITS-1:0] adj;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            if (req.base16)
            begin
                bcd_next  = {{(4*BCD_DIGITS-CONV_BITS){1'b0}}, mag};
                done_next = 1'b1;
            end
            else
            begin
                bin_next  = mag;
                bcd_next  = '0;
                cnt_next  = 7'(CONV_BITS);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            bcd_next = {adj[4*BCD_DIGITS-2:0], bin_reg[CONV_BITS-1]};
            bin_next = {bin_reg[CONV_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done   = done_reg;
    assign digits = bcd_reg;

endmodule

[rtl/printf_integer_field_formatter_top.sv]
// ---------------------------------------------------------------------------
// printf_integer_field_formatter_top
// Formats one parsed printf item into a stream of ASCII bytes.
// ---------------------------------------------------------------------------
// Input channel: in_valid / in_stall carries one item (kind, value, size,
// width, flags, character). in_stall is high while an item is in work.
// Output channel: out_valid / out_stall carries one byte per transaction,
// with last set on the final byte of the item.
// Decimal kinds run a shift-add-3 converter; the sequencer sees it finish
// in S_CONV, sizes the field in S_LEN, then emits one byte per cycle while
// the output is not stalled. Hex and pointer kinds skip the shift-add-3
// pass but still go through S_CONV and S_LEN.
// Literal, char and shown kinds go straight to emission.
// A stalled output holds its byte and the sequencer waits with it; the
// next item is taken once the last byte sits in the output register.
// Reset clears the sequencer and the output valid; no clearing pass.
// ---------------------------------------------------------------------------
`include "printf_integer_field_formatter_top_macros.svh"

module printf_integer_field_formatter_top
    import ifmt_pkg::*;
#(
    parameter int WIDTH_MAX = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [63:0] value,
    input  logic [1:0]  size_code,
    input  logic [5:0]  field_width,
    input  logic        zero_pad,
    input  logic        alternate,
    input  logic [7:0]  character,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        last
);

    localparam int          WCAP_I = (WIDTH_MAX < RESULT_MAX) ? WIDTH_MAX : RESULT_MAX;
    localparam logic [6:0]  WCAP   = 7'(WCAP_I);

    typedef enum logic [1:0] {S_IDLE, S_CONV, S_LEN, S_EMIT} state_t;

    state_t      state_reg;
    logic [2:0]  kind_reg;
    logic        neg_reg, upper_reg, min16_reg, zero_reg;
    logic [1:0]  plen_reg;
    logic [5:0]  wsat_reg, total_reg, lead_reg, pos_reg;
    logic [7:0]  ch_reg, vbyte_reg;
    logic [4:0]  count_reg;
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        last_reg;

    logic        accept;
    logic [63:0] mask, narrowed, mag_c;
    logic        sign_c, neg_c, hex_c, numeric_c;
    logic [5:0]  wsat_c;
    conv_req_t   req;
    logic        conv_done;
    logic [4*BCD_DIGITS-1:0] digits;

    assign accept = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        unique case (size_code)
            SIZE_HH:   mask = 64'h0000_0000_0000_00ff;
            SIZE_H:    mask = 64'h0000_0000_0000_ffff;
            SIZE_LONG: mask = 64'hffff_ffff_ffff_ffff;
            default:   mask = 64'h0000_0000_ffff_ffff;
        endcase
        narrowed = value & mask;
        unique case (size_code)
            SIZE_HH:   sign_c = value[7];
            SIZE_H:    sign_c = value[15];
            SIZE_LONG: sign_c = value[63];
            default:   sign_c = value[31];
        endcase
        neg_c = (kind == KIND_SDEC) && sign_c;
        if (neg_c)
            mag_c = 64'd0 - (narrowed | ~mask);
        else if (kind == KIND_PTR)
            mag_c = value;
        else
            mag_c = narrowed;
        hex_c = (kind == KIND_HEXL) || (kind == KIND_HEXU) || (kind == KIND_PTR);
        numeric_c = (kind == KIND_SDEC) || (kind == KIND_UDEC) || hex_c;
        wsat_c = ({1'b0, field_width} > WCAP) ? WCAP[5:0] : field_width;
        req.start  = accept && numeric_c;
        req.base16 = hex_c;
    end

    ifmt_bcd u_bcd
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .mag    (mag_c),
        .done   (conv_done),
        .digits (digits)
    );

    logic [4:0] cnt_c;
    logic [4:0] len_c;
    always_comb
    begin
        cnt_c = 5'd1;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (digits[4*i +: 4] != 4'd0)
                cnt_c = 5'(i + 1);
        end
        if (min16_reg && cnt_c < 5'd16)
            cnt_c = 5'd16;
        len_c = cnt_c + {3'd0, plen_reg} + {4'd0, neg_reg};
    end

    logic [5:0] from_end, rel, rel2;
    logic [3:0] nib;
    logic [7:0] byte_c;
    logic       emit_go, is_last;
    always_comb
    begin
        from_end = total_reg - 6'd1 - pos_reg;
        rel      = pos_reg - lead_reg;
        rel2     = rel - {5'd0, neg_reg};
        nib      = digits[{from_end[4:0], 2'b00} +: 4];
        case (kind_reg)
            KIND_LITERAL: byte_c = ch_reg;
            KIND_CHAR:    byte_c = (from_end == 6'd0) ? vbyte_reg : CH_SPACE;
            KIND_SHOWN:   byte_c = (pos_reg == 6'd0) ? CH_PERCENT : ch_reg;
            default:
            begin
                if (from_end < {1'b0, count_reg})
                    byte_c = digit_char(nib, upper_reg);
                else if (pos_reg < lead_reg)
                    byte_c = CH_SPACE;
                else if (neg_reg && rel == 6'd0)
                    byte_c = CH_MINUS;
                else if (rel2 < {4'd0, plen_reg})
                    byte_c = (rel2 == 6'd0) ? CH_ZERO : (upper_reg ? CH_X_UP : CH_X_LOW);
                else
                    byte_c = CH_ZERO;
            end
        endcase
        emit_go = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
        is_last = (from_end == 6'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (emit_go)
                out_valid_reg <= 1'b1;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                        state_reg <= numeric_c ? S_CONV : S_EMIT;
                end
                S_CONV:
                begin
                    if (conv_done)
                        state_reg <= S_LEN;
                end
                S_LEN:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (emit_go && is_last)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            neg_reg   <= neg_c;
            upper_reg <= (kind == KIND_HEXU);
            min16_reg <= (kind == KIND_PTR);
            zero_reg  <= zero_pad && numeric_c && (kind != KIND_PTR);
            if (kind == KIND_PTR)
                plen_reg <= 2'd2;
            else if ((kind == KIND_HEXL || kind == KIND_HEXU) && alternate
                     && narrowed != 64'd0)
                plen_reg <= 2'd2;
            else
                plen_reg <= 2'd0;
            wsat_reg  <= wsat_c;
            ch_reg    <= character;
            vbyte_reg <= value[7:0];
            pos_reg   <= '0;
            count_reg <= 5'd1;
            lead_reg  <= '0;
            case (kind)
                KIND_LITERAL: total_reg <= 6'd1;
                KIND_CHAR:    total_reg <= (wsat_c > 6'd1) ? wsat_c : 6'd1;
                KIND_SHOWN:   total_reg <= (character != 8'd0) ? 6'd2 : 6'd1;
                default:      total_reg <= 6'd1;
            endcase
        end
        if (state_reg == S_LEN)
        begin
            count_reg <= cnt_c;
            total_reg <= (wsat_reg > {1'b0, len_c}) ? wsat_reg : {1'b0, len_c};
            lead_reg  <= (!zero_reg && wsat_reg > {1'b0, len_c}) ?
                         (wsat_reg - {1'b0, len_c}) : 6'd0;
        end
        if (emit_go)
        begin
            out_byte_reg <= byte_c;
            last_reg     <= is_last;
            pos_reg      <= pos_reg + 6'd1;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last      = last_reg;

    `IFMT_ASSERT_NXT(a_busy_after_accept, accept, in_stall)
    `IFMT_ASSERT_IMP(a_last_leaves_emit, emit_go && is_last, state_reg == S_EMIT)
    `IFMT_ASSERT_IMP(a_count_nonzero, state_reg == S_EMIT, count_reg != 5'd0)
    `IFMT_ASSERT_NXT(a_conv_done_len, state_reg == S_CONV && conv_done, state_reg == S_LEN)

endmodule
